### design/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies consequent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition never holds
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/bbl_pkg.sv
package bbl_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_W      = 11;
  localparam int IDX_W      = 2;
  localparam int PIX_W      = 24;
  localparam int RECIP_SHIFT = 17;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_run;
    logic       end_of_frame;
  } pixel_out_t;

  typedef struct packed {
    logic load_sum;
    logic load_mul;
  } lane_ctrl_t;

  // ceil(2^RECIP_SHIFT / (2*cnt)), exact quotient for every value the lanes produce
  function automatic logic [16:0] recip(input logic [3:0] cnt);
    logic [16:0] r;
    case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

### design/bbl_rowbuf.sv
module bbl_rowbuf import bbl_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [PIX_W-1:0] older_wr,
  input  logic [PIX_W-1:0] newer_wr,
  output logic [PIX_W-1:0] older_q,
  output logic [PIX_W-1:0] newer_q
);

  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= older_wr;
      newer_mem[wr_addr] <= newer_wr;
    end
    if (rd_en) begin
      older_q <= older_mem[rd_addr];
      newer_q <= newer_mem[rd_addr];
    end
  end

endmodule

### design/bbl_lane.sv
`include "assert_macros.svh"

module bbl_lane import bbl_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  lane_ctrl_t      ctrl,
  input  logic [8:0][7:0] taps,
  input  logic [8:0]      tap_valid,
  output logic [7:0]      mean
);

  logic [11:0] sum;
  logic [11:0] sum_next;
  logic [3:0]  cnt;
  logic [3:0]  cnt_next;
  logic [29:0] prod;
  logic [12:0] num;

  always_comb begin
    sum_next = '0;
    cnt_next = '0;
    for (int i = 0; i < 9; i++) begin
      if (tap_valid[i]) begin
        sum_next = sum_next + 12'(taps[i]);
        cnt_next = cnt_next + 4'd1;
      end
    end
  end

  // rounded numerator 2*sum + count
  assign num = {sum, 1'b0} + 13'(cnt);

  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      sum <= sum_next;
      cnt <= cnt_next;
    end
    if (ctrl.load_mul) begin
      prod <= 30'(num) * 30'(recip(cnt));
    end
  end

  assign mean = prod[RECIP_SHIFT +: 8];

  `ASSERT_IMPLIES(a_cnt_nonzero, ctrl.load_mul, cnt != 4'd0, "lane divides by empty window")

endmodule

### design/box_blur_3x3_edge_aware.sv
// path: a pixel's results pass the row buffer read, the lane sum and multiply registers and the output register
// each input gives 0 to 4 results, one pixel at a time: a new pixel is taken only once the last one is done
// the row buffer read port and the shared sum/multiply lanes serialise this work
// reset: counters and column window clear, frame size returns to 640 x 480
// row buffers are not cleared; no result reads an entry not written this frame
`include "assert_macros.svh"

module box_blur_3x3_edge_aware import bbl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pixel_in_t        in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pixel_out_t       out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0]       state;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [2:0][PIX_W-1:0] win0;
  logic [2:0][PIX_W-1:0] win1;
  logic [2:0][PIX_W-1:0] ncol;
  logic [2:0][PIX_W-1:0] ncol_cur;
  logic [PIX_W-1:0] pix;
  logic             row_end_q;
  logic             last_row_q;
  logic             r_ge1;
  logic             r_ge2;
  logic             c_ge2;
  logic [3:0]       pending;
  logic [3:0]       pending_clr;
  logic [1:0]       sel;

  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             row_end_c;
  logic             last_row_c;
  logic             in_beat;
  logic             out_free;
  logic             finish;

  logic [PIX_W-1:0] older_q;
  logic [PIX_W-1:0] newer_q;

  logic [2:0][2:0][PIX_W-1:0] cols;
  logic [2:0]       col_valid;
  logic [2:0]       row_valid;
  logic [2:0][8:0][7:0] taps;
  logic [8:0]       tap_valid;
  logic [2:0][7:0]  means;
  lane_ctrl_t       lane_ctrl;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(640);
      frame_height <= CFG_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = frame_width;
    if (frame_width < CFG_W'(2)) w_eff = CFG_W'(2);
    else if (frame_width > CFG_W'(MAX_WIDTH)) w_eff = CFG_W'(MAX_WIDTH);
    h_eff = frame_height;
    if (frame_height < CFG_W'(1)) h_eff = CFG_W'(1);
    else if (frame_height > CFG_W'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
  end

  assign row_end_c  = (CFG_W'(column_count) + CFG_W'(1)) >= w_eff;
  assign last_row_c = (CFG_W'(row_count) + CFG_W'(1)) >= h_eff;

  bbl_rowbuf u_rowbuf (
    .clk      (clk),
    .rd_en    (in_beat),
    .rd_addr  (column_count),
    .wr_en    (state == S_READ),
    .wr_addr  (column_count),
    .older_wr (newer_q),
    .newer_wr (pix),
    .older_q  (older_q),
    .newer_q  (newer_q)
  );

  // slot 0 = row r-2, slot 1 = row r-1, slot 2 = row r
  assign ncol_cur = (state == S_READ) ? {pix, newer_q, older_q} : ncol;

  // lowest pending result goes first: 0/1 for row r-1, 2/3 for the final row
  always_comb begin
    if (pending[0])      sel = 2'd0;
    else if (pending[1]) sel = 2'd1;
    else if (pending[2]) sel = 2'd2;
    else                 sel = 2'd3;
  end

  assign pending_clr = pending & ~(4'b0001 << sel);

  always_comb begin
    if (!sel[0]) begin
      cols      = {ncol, win0, win1};
      col_valid = {1'b1, 1'b1, c_ge2};
    end else begin
      cols      = {ncol, ncol, win0};
      col_valid = 3'b011;
    end
    if (!sel[1]) row_valid = {1'b1, 1'b1, r_ge2};
    else         row_valid = {1'b1, r_ge1, 1'b0};
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int ci = 0; ci < 3; ci++) begin
        for (int ri = 0; ri < 3; ri++) begin
          taps[j][ci*3 + ri] = cols[ci][ri][(2 - j)*8 +: 8];
        end
      end
    end
    for (int ci = 0; ci < 3; ci++) begin
      for (int ri = 0; ri < 3; ri++) begin
        tap_valid[ci*3 + ri] = col_valid[ci] && row_valid[ri];
      end
    end
  end

  assign lane_ctrl.load_sum = (state == S_SUM);
  assign lane_ctrl.load_mul = (state == S_MUL);

  // lane 0 red, lane 1 green, lane 2 blue
  for (genvar j = 0; j < 3; j++) begin : g_lane
    bbl_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (lane_ctrl),
      .taps      (taps[j]),
      .tap_valid (tap_valid),
      .mean      (means[j])
    );
  end

  assign finish = ((state == S_READ) && (pending == 4'd0))
               || ((state == S_PUT) && out_free && (pending_clr == 4'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= '0;
      row_count    <= '0;
      win0         <= '0;
      win1         <= '0;
      pending      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            pending <= {last_row_c && row_end_c,
                        last_row_c && (column_count != '0),
                        (row_count != '0) && row_end_c,
                        (row_count != '0) && (column_count != '0)};
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= (pending == 4'd0) ? S_IDLE : S_SUM;
        end
        S_SUM: state <= S_MUL;
        S_MUL: state <= S_PUT;
        S_PUT: begin
          if (out_free) begin
            pending <= pending_clr;
            state   <= (pending_clr == 4'd0) ? S_IDLE : S_SUM;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (finish) begin
        win1 <= win0;
        win0 <= ncol_cur;
        if (row_end_q) begin
          column_count <= '0;
          row_count    <= last_row_q ? '0 : row_count + ROW_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
        end
      end
    end
  end

  // per-pixel payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat) begin
      pix        <= in_data;
      row_end_q  <= row_end_c;
      last_row_q <= last_row_c;
      r_ge1      <= (row_count != '0);
      r_ge2      <= (row_count > ROW_W'(1));
      c_ge2      <= (column_count > COL_W'(1));
    end
    if (state == S_READ) begin
      ncol <= ncol_cur;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_PUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PUT) && out_free) begin
      out_data.out_red      <= means[0];
      out_data.out_green    <= means[1];
      out_data.out_blue     <= means[2];
      out_data.last_of_run  <= (pending_clr == 4'd0);
      out_data.end_of_frame <= (sel == 2'd3);
    end
  end

  `ASSERT_NEVER(a_no_empty_result, ((state == S_SUM) || (state == S_PUT)) && (pending == 4'd0), "result stage with nothing pending")
  `ASSERT_IMPLIES(a_eof_closes_run, out_valid && out_data.end_of_frame, out_data.last_of_run, "frame end not last of run")
  `ASSERT_NEXT(a_read_follows_beat, in_beat, state == S_READ, "row buffer read skipped")

endmodule
